### design/asp_pkg.sv
`timescale 1ns / 1ps

package asp_pkg;

	// configuration register indexes
	localparam logic CFG_LO_DEG = 1'b0;
	localparam logic CFG_HI_DEG = 1'b1;

	// item kinds carried on tuser
	localparam logic FUNC_LOAD    = 1'b0;
	localparam logic FUNC_MEASURE = 1'b1;

	localparam logic signed [7:0] LO_DEG_RST = -8'sd40;
	localparam logic signed [7:0] HI_DEG_RST = 8'sd87;

	// divide by 10 as x * 52429 >> 19, exact for all 16-bit magnitudes
	localparam int unsigned TEMP_RECIP = 52429;
	localparam int unsigned TEMP_SHIFT = 19;

	// pascals: counts * 122070 / (450 * 928), reduced by the common factor 30
	localparam int unsigned ADC_UV100  = 122070;
	localparam int unsigned SENS_UV_PA = 450;
	localparam int unsigned GAIN_X100  = 928;
	localparam int unsigned PA_GCD     = 30;
	localparam int unsigned PA_NUM     = ADC_UV100 / PA_GCD;
	localparam int unsigned PA_DEN     = (SENS_UV_PA * GAIN_X100) / PA_GCD;
	localparam int unsigned PA_SHIFT   = 32;
	localparam longint unsigned PA_RECIP = (64'd1 << PA_SHIFT) / PA_DEN;

	// pa * 327680 / 3 = m * 21845 + m / 3 with m = pa * 5
	localparam int unsigned SPD_K      = 21845;
	localparam int unsigned DIV3_RECIP = 43691;
	localparam int unsigned DIV3_SHIFT = 17;

	// square root working pair: remainder and developing root
	typedef struct packed {
		logic [26:0] rem;
		logic [27:0] res;
	} sq_t;

endpackage

### design/asp_ram.sv
`timescale 1ns / 1ps

module asp_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### design/airspeed_from_pressure.sv
`timescale 1ns / 1ps

// Airspeed from a differential-pressure sample. Items on the s_ side are loads (tuser 0), which
// write one zero-offset entry of the temperature table, or measures (tuser 1), which return
// compensated pressure in pascals and airspeed in unsigned Q6.8 on the m_ side. The block takes
// one item per clock while s_tready is high and holds 18 register stages: m_tvalid rises when a
// measure item reaches the last stage, and the result leaves at the next edge when the output is not stalled.
// Loads write the table in stage 3, the stage where measures read it, so a measure right behind
// a load already sees the new entry; loads return nothing. Empty stages keep filling while a
// result waits, and s_tready drops only when every stage is occupied. Table entries hold no
// value until written and are not cleared at reset. The user must write the lower and upper
// temperature limits only while no item is in flight; the block itself does not enforce this.
module airspeed_from_pressure import asp_pkg::*; #(
	parameter int TABLE_DEPTH = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,   // raw_sample, temp_tenths, entry_index, entry_value, pad
	input  logic        s_tuser,   // func
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // pressure_pa, airspeed_q8, pad
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int NS = 18;
	localparam logic signed [13:0] IDX_MAX = 14'(TABLE_DEPTH - 1);

	logic signed [7:0] lo_deg_q, hi_deg_q;

	logic [NS:1]   vld_s;
	logic [NS:1]   vld_in;
	logic [NS+1:1] en;

	// input fields
	logic [11:0] raw_sample;
	logic [15:0] temp_tenths;
	logic [6:0]  entry_index;
	logic [15:0] entry_value;

	assign raw_sample  = s_tdata[11:0];
	assign temp_tenths = s_tdata[27:12];
	assign entry_index = s_tdata[34:28];
	assign entry_value = s_tdata[50:35];

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_deg_q <= LO_DEG_RST;
			hi_deg_q <= HI_DEG_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_LO_DEG: lo_deg_q <= signed'(cfg_data);
				CFG_HI_DEG: hi_deg_q <= signed'(cfg_data);
				default: ;
			endcase
		end
	end

	// stage enables: a stage moves when it is empty or the next one moves
	always_comb begin
		en[NS+1] = m_tready;
		for (int k = NS; k >= 1; k--) begin
			en[k] = !vld_s[k] || en[k+1];
		end
	end

	assign s_tready = en[1];

	logic func_s2;

	always_comb begin
		vld_in[1] = s_tvalid;
		for (int k = 2; k <= NS; k++) begin
			vld_in[k] = vld_s[k-1];
		end
		// loads end at the table write
		vld_in[3] = vld_s[2] && (func_s2 == FUNC_MEASURE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			for (int k = 1; k <= NS; k++) begin
				if (en[k]) begin
					vld_s[k] <= vld_in[k];
				end
			end
		end
	end

	// stage 1: magnitude of the temperature times the reciprocal of ten
	logic        func_s1, tneg_s1;
	logic [31:0] tprod_s1;
	logic [11:0] raw_s1;
	logic [6:0]  eidx_s1;
	logic [15:0] eval_s1;
	logic [15:0] tmag;

	assign tmag = temp_tenths[15] ? 16'(-temp_tenths) : temp_tenths;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			func_s1  <= s_tuser;
			tneg_s1  <= temp_tenths[15];
			tprod_s1 <= 32'(tmag) * 32'(TEMP_RECIP);
			raw_s1   <= raw_sample;
			eidx_s1  <= entry_index;
			eval_s1  <= entry_value;
		end
	end

	// stage 2: signed whole degrees, clamp and table index
	logic [11:0]       tq;
	logic signed [13:0] t0, t1, t2, lo14, hi14, dlt;
	logic [AW-1:0]     idx;
	logic [AW-1:0]     idx_s2;
	logic [11:0]       raw_s2;
	logic [6:0]        eidx_s2;
	logic [15:0]       eval_s2;

	always_comb begin
		tq   = tprod_s1[TEMP_SHIFT +: 12];
		t0   = tneg_s1 ? -signed'(14'(tq)) : signed'(14'(tq));
		lo14 = 14'(lo_deg_q);
		hi14 = 14'(hi_deg_q);
		t1   = (t0 < lo14) ? lo14 : t0;
		t2   = (t1 > hi14) ? hi14 : t1;
		dlt  = t2 - lo14;
		if (dlt < 0) begin
			idx = '0;
		end else if (dlt > IDX_MAX) begin
			idx = IDX_MAX[AW-1:0];
		end else begin
			idx = dlt[AW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			func_s2 <= func_s1;
			idx_s2  <= idx;
			raw_s2  <= raw_s1;
			eidx_s2 <= eidx_s1;
			eval_s2 <= eval_s1;
		end
	end

	// stage 3: table write for loads, table read for measures
	logic [8:0]  eidx_ext;
	logic        tbl_we, tbl_re;
	logic [15:0] zero_s3;
	logic [11:0] raw_s3;

	assign eidx_ext = 9'(eidx_s2);
	assign tbl_we   = en[3] && vld_s[2] && (func_s2 == FUNC_LOAD) &&
		(eidx_ext < 9'(TABLE_DEPTH));
	assign tbl_re   = en[3] && vld_s[2] && (func_s2 == FUNC_MEASURE);

	asp_ram #(
		.WIDTH (16),
		.DEPTH (TABLE_DEPTH)
	) u_zero_table (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (eidx_ext[AW-1:0]),
		.wdata (eval_s2),
		.re    (tbl_re),
		.raddr (idx_s2),
		.rdata (zero_s3)
	);

	always_ff @(posedge clk) begin
		if (en[3]) begin
			raw_s3 <= raw_s2;
		end
	end

	// stage 4: offset removal, floored at zero
	logic [11:0] p_s4;

	always_ff @(posedge clk) begin
		if (en[4]) begin
			p_s4 <= (zero_s3 >= 16'(raw_s3)) ? '0 : 12'(16'(raw_s3) - zero_s3);
		end
	end

	// stages 5 to 8: pascals by reciprocal multiply with one correction step
	logic [23:0] n_s5, n_s6, n_s7, qd_s7, diff;
	logic [10:0] q0_s6, q0_s7, pa_s8;
	logic [42:0] qprod;

	assign qprod = 43'(n_s5) * 43'(PA_RECIP);
	assign diff  = n_s7 - qd_s7;

	always_ff @(posedge clk) begin
		if (en[5]) begin
			n_s5 <= 24'(p_s4) * 24'(PA_NUM);
		end
		if (en[6]) begin
			n_s6  <= n_s5;
			q0_s6 <= qprod[PA_SHIFT +: 11];
		end
		if (en[7]) begin
			n_s7  <= n_s6;
			q0_s7 <= q0_s6;
			qd_s7 <= 24'(q0_s6) * 24'(PA_DEN);
		end
		if (en[8]) begin
			pa_s8 <= q0_s7 + 11'(diff >= 24'(PA_DEN));
		end
	end

	// stages 9 to 11: radicand pa * 327680 / 3
	logic [12:0] m_s9;
	logic [10:0] pa_s9, pa_s10;
	logic [26:0] a_s10;
	logic [10:0] b_s10;
	logic [28:0] bprod;

	assign bprod = 29'(m_s9) * 29'(DIV3_RECIP);

	always_ff @(posedge clk) begin
		if (en[9]) begin
			m_s9  <= (13'(pa_s8) << 2) + 13'(pa_s8);
			pa_s9 <= pa_s8;
		end
		if (en[10]) begin
			a_s10  <= 27'(m_s9) * 27'(SPD_K);
			b_s10  <= bprod[DIV3_SHIFT +: 11];
			pa_s10 <= pa_s9;
		end
	end

	// stage 11 loads the radicand; stages 12 to 18: square root, two result bits per stage
	sq_t         sq_s   [11:NS];
	logic [10:0] sq_pa_s [11:NS];
	sq_t         sq_nxt [12:NS];

	function automatic sq_t sq_step(sq_t a, int unsigned sh);
		sq_t         r;
		logic [27:0] bitv;
		logic [27:0] trial;
		bitv  = 28'(1) << sh;
		trial = a.res + bitv;
		r     = a;
		if ({1'b0, a.rem} >= trial) begin
			r.rem = a.rem - trial[26:0];
			r.res = (a.res >> 1) + bitv;
		end else begin
			r.res = a.res >> 1;
		end
		return r;
	endfunction

	always_ff @(posedge clk) begin
		if (en[11]) begin
			sq_s[11].rem <= a_s10 + 27'(b_s10);
			sq_s[11].res <= '0;
			sq_pa_s[11]  <= pa_s10;
		end
	end

	for (genvar k = 12; k <= NS; k++) begin : g_sqrt
		always_comb begin
			sq_nxt[k] = sq_step(sq_step(sq_s[k-1], 26 - 4 * (k - 12)), 24 - 4 * (k - 12));
		end

		always_ff @(posedge clk) begin
			if (en[k]) begin
				sq_s[k]    <= sq_nxt[k];
				sq_pa_s[k] <= sq_pa_s[k-1];
			end
		end
	end

	assign m_tvalid = vld_s[NS];
	assign m_tdata  = {7'b0, sq_s[NS].res[13:0], sq_pa_s[NS]};

`ifndef SYNTHESIS
	// floor square root leaves a remainder no larger than twice the root
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ({2'b0, sq_s[NS].rem} <= {sq_s[NS].res, 1'b0}))
		else $error("square root remainder out of range");

	// the reciprocal estimate is off by at most one quotient step
	assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[7] |-> ({1'b0, n_s7 - qd_s7} < 25'(2 * PA_DEN)))
		else $error("pascal quotient estimate off by more than one");

	assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[8] |-> (pa_s8 <= 11'd1197))
		else $error("pressure above full scale");

	// a load leaves the pipeline at the table write
	assert property (@(posedge clk) disable iff (!arst_n)
		(en[3] && vld_s[2] && (func_s2 == FUNC_LOAD)) |=> !vld_s[3])
		else $error("load item passed the table stage");
`endif

endmodule

### test/airspeed_checker.sv
`timescale 1ns / 1ps

module airspeed_checker import asp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [55:0] s_tdata,   // raw_sample, temp_tenths, entry_index, entry_value, pad
	input  logic        s_tuser,   // func
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,   // pressure_pa, airspeed_q8, pad
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data,
	output int          mismatches,
	output int          pending
);

	localparam int   DEPTH        = 128;
	localparam longint unsigned SPEED_NUM = 327680;
	localparam longint unsigned SPEED_DEN = 3;

	typedef struct packed {
		logic [13:0] airspeed_q8;
		logic [10:0] pressure_pa;
	} airspeed_t;

	logic [15:0]       offset_table [DEPTH];
	logic signed [7:0] lo_deg;
	logic signed [7:0] hi_deg;
	airspeed_t         expected_airspeed [$];
	airspeed_t         want;
	airspeed_t         got;
	int                result_no;

	function automatic airspeed_t predict_airspeed(input logic [11:0] raw,
			input logic signed [15:0] tenths);
		int              deg;
		int              slot;
		logic [15:0]     zero;
		longint unsigned counts;
		longint unsigned pascals;
		longint unsigned radicand;
		longint unsigned root;
		longint unsigned trial;
		int              b;
		airspeed_t       r;
		// truncates toward zero like the hardware divider
		deg = int'(tenths) / 10;
		// lower clamp first, so an inverted range ends at the upper bound
		if (deg < int'(lo_deg)) deg = int'(lo_deg);
		if (deg > int'(hi_deg)) deg = int'(hi_deg);
		slot = deg - int'(lo_deg);
		if (slot < 0) slot = 0;
		if (slot > DEPTH - 1) slot = DEPTH - 1;
		zero = offset_table[slot[6:0]];
		if (zero >= {4'b0, raw})
			counts = 0;
		else
			counts = longint'(raw) - longint'(zero);
		pascals = ((counts * ADC_UV100) / SENS_UV_PA) / GAIN_X100;
		radicand = (pascals * SPEED_NUM) / SPEED_DEN;
		root = 0;
		for (b = 15; b >= 0; b--) begin
			trial = root | (64'd1 << b);
			if (trial * trial <= radicand) root = trial;
		end
		r.pressure_pa = pascals[10:0];
		r.airspeed_q8 = root[13:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_deg = LO_DEG_RST;
			hi_deg = HI_DEG_RST;
			expected_airspeed.delete();
			mismatches = 0;
			pending = 0;
			result_no = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_LO_DEG)
					lo_deg = cfg_data;
				else if (cfg_index == CFG_HI_DEG)
					hi_deg = cfg_data;
			end
			if (m_tvalid && m_tready) begin
				got = m_tdata[24:0];
				if (expected_airspeed.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result %0d with nothing expected: pressure %0d speed %0d",
							result_no, got.pressure_pa, got.airspeed_q8);
				end else begin
					want = expected_airspeed.pop_front();
					if (want.pressure_pa !== got.pressure_pa ||
							want.airspeed_q8 !== got.airspeed_q8) begin
						mismatches++;
						if (mismatches <= 10)
							$display("result %0d: pressure exp %0d got %0d, speed exp %0d got %0d",
								result_no, want.pressure_pa, got.pressure_pa,
								want.airspeed_q8, got.airspeed_q8);
					end
				end
				result_no++;
			end
			if (s_tvalid && s_tready) begin
				if (s_tuser == FUNC_LOAD)
					offset_table[s_tdata[34:28]] = s_tdata[50:35];
				else if (s_tuser == FUNC_MEASURE)
					expected_airspeed.push_back(predict_airspeed(s_tdata[11:0], s_tdata[27:12]));
			end
			pending = expected_airspeed.size();
		end
	end

endmodule

### test/airspeed_from_pressure_tb.sv
`timescale 1ns / 1ps

module airspeed_from_pressure_tb import asp_pkg::*; ();

	localparam int   HOLD_CYCLES  = 300;
	localparam int   DRAIN_CYCLES = 24;
	localparam int   CYCLE_LIMIT  = 300000;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [55:0] s_tdata;   // raw_sample, temp_tenths, entry_index, entry_value, pad
	logic        s_tuser;   // func
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;   // pressure_pa, airspeed_q8, pad
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_index;
	logic [7:0]  cfg_data;

	int mismatches;
	int pending;
	int send_idle;
	int recv_idle;
	int cycles = 0;
	int n_loads = 0;
	int n_measures = 0;
	int n_ranges = 1;
	int cur_lo = int'(LO_DEG_RST);
	int cur_hi = int'(HI_DEG_RST);
	int hold_cnt = 0;
	logic hold_req = 1'b0;
	logic hold_done = 1'b0;

	airspeed_from_pressure DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	airspeed_checker u_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.mismatches(mismatches),
		.pending   (pending)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// output side: random backpressure, plus one long hold on request
	always @(negedge clk) begin
		if (hold_req && !hold_done) begin
			m_tready <= 1'b0;
			hold_cnt++;
			if (hold_cnt >= HOLD_CYCLES) hold_done = 1'b1;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= recv_idle);
		end
	end

	// called at a falling edge, returns at a falling edge
	task automatic offer(input logic [55:0] d, input logic u);
		while ($urandom_range(0, 99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= d;
		s_tuser <= u;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
	endtask

	// unused fields of an item carry random bits
	task automatic send_load(input logic [6:0] slot, input logic [15:0] offset);
		logic [55:0] d;
		d = {$urandom, $urandom};
		d[55:51] = '0;
		d[34:28] = slot;
		d[50:35] = offset;
		offer(d, FUNC_LOAD);
		n_loads++;
	endtask

	task automatic send_measure(input logic [11:0] raw, input logic [15:0] tenths);
		logic [55:0] d;
		d = {$urandom, $urandom};
		d[55:51] = '0;
		d[11:0] = raw;
		d[27:12] = tenths;
		offer(d, FUNC_MEASURE);
		n_measures++;
	endtask

	task automatic set_range(input int lo, input int hi);
		s_tvalid <= 1'b0;
		wait (pending == 0);
		// loads give nothing back, so let the pipe empty
		repeat (DRAIN_CYCLES) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_LO_DEG;
		cfg_data <= lo[7:0];
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_index <= CFG_HI_DEG;
		cfg_data <= hi[7:0];
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		cur_lo = lo;
		cur_hi = hi;
		n_ranges++;
	endtask

	function automatic logic [15:0] pick_tenths();
		int a;
		int b;
		a = ((cur_lo < cur_hi) ? cur_lo : cur_hi) * 10 - 30;
		b = ((cur_lo < cur_hi) ? cur_hi : cur_lo) * 10 + 30;
		if ($urandom_range(0, 9) < 6)
			return 16'(a + int'($urandom_range(0, b - a)));
		return 16'($urandom);
	endfunction

	function automatic logic [11:0] pick_raw();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0) return 12'd0;
		if (r < 3) return 12'hFFF;
		return 12'($urandom_range(0, 4095));
	endfunction

	function automatic logic [15:0] pick_offset();
		int r;
		r = $urandom_range(0, 19);
		if (r < 3) return 16'd0;
		if (r < 6) return 16'($urandom);
		return 16'($urandom_range(0, 600));
	endfunction

	task automatic random_items(input int count);
		int i;
		for (i = 0; i < count; i++) begin
			if ($urandom_range(0, 3) == 0)
				send_load(7'($urandom), pick_offset());
			else
				send_measure(pick_raw(), pick_tenths());
		end
	endtask

	initial begin
		int i;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = FUNC_LOAD;
		cfg_valid = 1'b0;
		cfg_index = CFG_LO_DEG;
		cfg_data = '0;
		send_idle = 34;
		recv_idle = 86;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// every entry gets a value before any lookup
		for (i = 0; i < 128; i++)
			send_load(7'(i), 16'($urandom_range(0, 300)));

		// directed part under the reset range: 0 degrees is entry 40
		send_load(7'd40, 16'd0);
		send_measure(12'hFFF, 16'd0);
		send_measure(12'd0, 16'd5);
		send_load(7'd40, 16'd4095);
		send_measure(12'hFFF, -16'sd5);
		send_load(7'd40, 16'hFFFF);
		send_measure(12'd100, 16'd9);
		send_load(7'd41, 16'd99);
		send_measure(12'd100, 16'd15);
		send_load(7'd39, 16'd10);
		send_measure(12'hFFF, -16'sd15);
		send_measure(12'hFFF, 16'h8000);
		send_measure(12'hFFF, 16'h7FFF);
		send_measure(12'd3000, -16'sd400);
		send_measure(12'd3000, -16'sd401);
		send_measure(12'd3000, 16'd870);
		send_measure(12'd3000, 16'd879);
		send_load(7'd127, 16'hFFFF);
		send_measure(12'hFFF, 16'd2000);
		send_load(7'd127, 16'd0);
		send_measure(12'hFFF, 16'd2000);

		random_items(50);

		send_idle = 86;
		recv_idle = 34;
		set_range(-128, 127);
		random_items(100);
		// let everything drain before going on
		s_tvalid <= 1'b0;
		wait (pending == 0);
		@(negedge clk);
		random_items(100);

		send_idle = 0;
		recv_idle = 0;
		set_range(127, -128);
		random_items(40);
		set_range(-128, -128);
		random_items(40);
		set_range(127, 127);
		random_items(40);
		set_range($urandom_range(0, 255) - 128, $urandom_range(0, 255) - 128);
		random_items(60);
		hold_req = 1'b1;
		random_items(120);

		s_tvalid <= 1'b0;
		wait (pending == 0);
		repeat (40) @(posedge clk);
		$display("covered %0d measures and %0d table loads over %0d temperature ranges",
			n_measures, n_loads, n_ranges);
		$display("with idle gaps on both sides, a %0d-cycle output hold and a full drain pause",
			HOLD_CYCLES);
		if (mismatches == 0 && pending == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

### airspeed_from_pressure.f
design/asp_pkg.sv
design/asp_ram.sv
design/airspeed_from_pressure.sv
test/airspeed_checker.sv
test/airspeed_from_pressure_tb.sv
